[hw/rtl/ple_pkg.sv]
// Shared types and codes for the positional list engine.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

   localparam int MAX_INDEX_WIDTH = 8;

   localparam logic [3:0] ACT_CLEAR      = 4'd0;
   localparam logic [3:0] ACT_INS_FRONT  = 4'd1;
   localparam logic [3:0] ACT_DEL_FRONT  = 4'd2;
   localparam logic [3:0] ACT_APPEND     = 4'd3;
   localparam logic [3:0] ACT_REMOVE     = 4'd4;
   localparam logic [3:0] ACT_INS_BEFORE = 4'd5;
   localparam logic [3:0] ACT_INS_AFTER  = 4'd6;
   localparam logic [3:0] ACT_SET        = 4'd7;
   localparam logic [3:0] ACT_GET        = 4'd8;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_WRITE
   } ple_op_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      ple_op_type                 op;
      logic [MAX_INDEX_WIDTH-1:0] index;
   } ple_ctl_type;

endpackage
`default_nettype wire

[hw/rtl/ple_cell.sv]
// One storage cell of the list chain: holds one element and shifts to or
// from its neighbours under the broadcast command. Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ple_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CELL_INDEX = 0
) (
   input  wire                        clock,
   input  wire                        step_en,
   input  ple_pkg::ple_ctl_type       ctl,
   input  wire  [DATA_WIDTH-1:0]      left_value,
   input  wire  [DATA_WIDTH-1:0]      right_value,
   input  wire  [DATA_WIDTH-1:0]      wr_value,
   output logic [DATA_WIDTH-1:0]      value,
   output logic [DATA_WIDTH-1:0]      read_value
);

   localparam logic [ple_pkg::MAX_INDEX_WIDTH-1:0] MyIndex =
      ple_pkg::MAX_INDEX_WIDTH'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  hit;
   logic                  behind;

   assign hit    = (ctl.index == MyIndex);
   assign behind = (MyIndex > ctl.index);

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         ple_pkg::OP_INSERT: begin
            if (hit) begin
               value_in = wr_value;
            end else if (behind) begin
               value_in = left_value;
            end
         end
         ple_pkg::OP_REMOVE: begin
            if (hit || behind) begin
               value_in = right_value;
            end
         end
         ple_pkg::OP_WRITE: begin
            if (hit) begin
               value_in = wr_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         value_ff <= value_in;
      end
   end

   assign value      = value_ff;
   assign read_value = value_ff & {DATA_WIDTH{hit}};

endmodule
`default_nettype wire

[hw/rtl/ple_ctrl.sv]
// Action decoder: checks count and position, picks the chain command and
// works out status and the new element count. Depends on ple_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ple_ctrl #(
   parameter int CAPACITY = 16
) (
   input  wire  [3:0]                       action,
   input  wire  [4:0]                       position,
   input  wire  [$clog2(CAPACITY+1)-1:0]    count,
   output ple_pkg::ple_ctl_type             ctl,
   output logic [1:0]                       status,
   output logic                             read_ok,
   output logic [$clog2(CAPACITY+1)-1:0]    count_next
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int EW = (CW > 5) ? CW : 5;
   localparam logic [EW-1:0] Cap = EW'(CAPACITY);

   logic [EW-1:0] pos_e;
   logic [EW-1:0] cnt_e;
   logic [EW-1:0] pos_m1;
   logic          full;
   logic          in_range;
   logic [EW-1:0] idx_e;

   assign pos_e    = EW'(position);
   assign cnt_e    = EW'(count);
   assign pos_m1   = pos_e - EW'(1);
   assign full     = (cnt_e >= Cap);
   assign in_range = (cnt_e != '0) && (pos_e != '0) && (pos_e <= cnt_e);

   always_comb begin
      ctl.op     = ple_pkg::OP_NONE;
      idx_e      = '0;
      status     = ple_pkg::ST_OK;
      read_ok    = 1'b0;
      count_next = count;
      case (action)
         ple_pkg::ACT_CLEAR: begin
            count_next = '0;
         end
         ple_pkg::ACT_INS_FRONT: begin
            if (full) begin
               status = ple_pkg::ST_FULL;
            end else begin
               ctl.op = ple_pkg::OP_INSERT;
            end
         end
         ple_pkg::ACT_DEL_FRONT: begin
            if (cnt_e == '0) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               ctl.op  = ple_pkg::OP_REMOVE;
               read_ok = 1'b1;
            end
         end
         ple_pkg::ACT_APPEND: begin
            if (full) begin
               status = ple_pkg::ST_FULL;
            end else begin
               ctl.op = ple_pkg::OP_INSERT;
               idx_e  = cnt_e;
            end
         end
         ple_pkg::ACT_REMOVE: begin
            if (!in_range) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               ctl.op  = ple_pkg::OP_REMOVE;
               idx_e   = pos_m1;
               read_ok = 1'b1;
            end
         end
         ple_pkg::ACT_INS_BEFORE: begin
            if (full) begin
               status = ple_pkg::ST_FULL;
            end else if (pos_e > cnt_e) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               ctl.op = ple_pkg::OP_INSERT;
               idx_e  = (pos_e == '0) ? '0 : pos_m1;
            end
         end
         ple_pkg::ACT_INS_AFTER: begin
            if (full) begin
               status = ple_pkg::ST_FULL;
            end else if (pos_e > cnt_e) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               ctl.op = ple_pkg::OP_INSERT;
               idx_e  = pos_e;
            end
         end
         ple_pkg::ACT_SET: begin
            if (!in_range) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               ctl.op = ple_pkg::OP_WRITE;
               idx_e  = pos_m1;
            end
         end
         ple_pkg::ACT_GET: begin
            if (!in_range) begin
               status = ple_pkg::ST_RANGE;
            end else begin
               idx_e   = pos_m1;
               read_ok = 1'b1;
            end
         end
         default: begin
            status = ple_pkg::ST_RANGE;
         end
      endcase
      if (ctl.op == ple_pkg::OP_INSERT) begin
         count_next = count + CW'(1);
      end else if (ctl.op == ple_pkg::OP_REMOVE) begin
         count_next = count - CW'(1);
      end
      // valid indexes always lie below the capacity, so the low bits suffice
      ctl.index = ple_pkg::MAX_INDEX_WIDTH'(idx_e[IW-1:0]);
   end

endmodule
`default_nettype wire

[hw/rtl/positional_list_engine_unit.sv]
// Top level of the positional list engine: decoder, chain of cells and
// registered result. Depends on ple_pkg, ple_ctrl and ple_cell.
//
// Ordered list of up to CAPACITY elements held in a row of cells; every
// action (insert, remove, set, get, clear) completes in the cycle it is
// accepted, with all cells behind the affected position shifting together
// under one broadcast command. The result is loaded into an output
// register on acceptance. A new word is accepted every cycle while
// the output register is empty or being taken, so the sustained rate is
// one word per cycle; the single output register sets that figure. Reset
// clears the element count and valid flag; cell contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine_unit #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // position[4:0], data_in[36:5], zero fill
   input  wire  [3:0]  req_tuser,   // action[3:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // data_out[31:0], count[36:32], is_empty[37], zero fill
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int W  = DATA_WIDTH;

   logic                  accept;
   ple_pkg::ple_ctl_type  ctl_raw;
   ple_pkg::ple_ctl_type  ctl;
   logic [1:0]            status;
   logic                  read_ok;
   logic [CW-1:0]         count_next;
   logic [CW-1:0]         count_ff;
   logic [W+31:0]         din_wide;
   logic [W-1:0]          wr_value;
   logic [W-1:0]          cell_value [CAPACITY];
   logic [W-1:0]          cell_read  [CAPACITY];
   logic [W-1:0]          read_value;
   logic [W+31:0]         read_wide;

   logic                  rsp_valid_ff;
   logic [1:0]            status_ff;
   logic [31:0]           data_out_ff;
   logic [CW+4:0]         count_wide;
   logic [4:0]            count_out_ff;
   logic                  empty_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ple_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .action    (req_tuser),
      .position  (req_tdata[4:0]),
      .count     (count_ff),
      .ctl       (ctl_raw),
      .status    (status),
      .read_ok   (read_ok),
      .count_next(count_next)
   );

   always_comb begin
      ctl = ctl_raw;
      if (!accept) begin
         ctl.op = ple_pkg::OP_NONE;
      end
   end

   // stored values keep the low bits of the 32-bit input, zero extended
   assign din_wide = {{W{1'b0}}, req_tdata[36:5]};
   assign wr_value = din_wide[W-1:0];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [W-1:0] left_value;
      logic [W-1:0] right_value;
      if (g == 0) begin : g_first
         assign left_value = wr_value;
      end else begin : g_mid
         assign left_value = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_inner
         assign right_value = cell_value[g+1];
      end
      ple_cell #(
         .DATA_WIDTH(W),
         .CELL_INDEX(g)
      ) u_cell (
         .clock      (clock),
         .step_en    (accept),
         .ctl        (ctl),
         .left_value (left_value),
         .right_value(right_value),
         .wr_value   (wr_value),
         .value      (cell_value[g]),
         .read_value (cell_read[g])
      );
   end

   always_comb begin
      read_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_value = read_value | cell_read[i];
      end
   end

   assign read_wide  = {32'b0, read_value};
   assign count_wide = {5'b0, count_next};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_next;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status;
         data_out_ff  <= read_ok ? read_wide[31:0] : 32'd0;
         count_out_ff <= count_wide[4:0];
         empty_ff     <= (count_next == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, empty_ff, count_out_ff, data_out_ff};
   assign rsp_tuser  = status_ff;

endmodule
`default_nettype wire

[hw/rtl/ple_checker.sv]
// Port-level checks on the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine_unit.
`timescale 1ns / 1ps
`default_nettype none
module ple_checker #(
   parameter int CAPACITY = 16
) (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata,
   input wire [1:0]  rsp_tuser
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW+4:0] CapWide = (CW + 5)'(CAPACITY);
   localparam logic [4:0]    CapLow  = CapWide[4:0];

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[37] == (rsp_tdata[36:32] == 5'd0)))
      else $error("empty flag disagrees with count");

   // a full refusal reports the list at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ple_pkg::ST_FULL) |-> (rsp_tdata[36:32] == CapLow))
      else $error("full status with count below capacity");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ple_pkg::ST_OK) |->
         (rsp_tdata[31:0] == 32'd0) && (rsp_tuser != 2'd3))
      else $error("failed action returned data or bad status");

endmodule

bind positional_list_engine_unit ple_checker #(
   .CAPACITY(CAPACITY)
) u_ple_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
`default_nettype wire

[bench/positional_list_engine_unit_tb.sv]
// Self-checking bench for the positional list engine: a directed table, then random
// actions, checked against table outcomes or a queue-based list predictor. Depends on
// ple_pkg and positional_list_engine_unit.
`timescale 1ns / 1ps
module positional_list_engine_unit_tb;

   localparam int LIST_CAPACITY = 16;
   localparam int RANDOM_WORDS  = 1450;
   localparam int HOLD_CYCLES   = 60;
   localparam int MAX_PRINTED   = 40;
   localparam logic [3:0] ACT_UNUSED_FIRST = 4'd9;
   localparam logic [3:0] ACT_UNUSED_LAST  = 4'd15;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data_out;
      logic [4:0]  count;
      logic        is_empty;
   } outcome_type;

   typedef struct packed {
      logic [3:0]  act;
      logic [4:0]  pos;
      logic [31:0] din;
      logic [4:0]  reps;
      logic        typed;
      outcome_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // position[4:0], data_in[36:5], zero fill
   logic [3:0]  req_tuser = '0;   // action[3:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // data_out[31:0], count[36:32], is_empty[37], zero fill
   logic [1:0]  rsp_tuser;        // status[1:0]

   logic [31:0]  list_q[$];       // predicted list contents, front first
   outcome_type  outcome_q[$];    // outcomes still to come out of the block
   int           mismatches = 0;
   int           rsp_hold_cycles = 0;
   bit           req_steady = 1'b0;
   bit           rsp_steady = 1'b0;
   stim_row_type stim_tbl [0:25];

   positional_list_engine_unit #(
      .CAPACITY   (LIST_CAPACITY),
      .DATA_WIDTH (32)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic outcome_type apply_action(input logic [3:0] act,
                                                input logic [4:0] pos,
                                                input logic [31:0] din);
      outcome_type o;
      int          n;
      int          p;
      bit          full;
      bit          in_range;
      n = list_q.size();
      p = pos;
      full = n >= LIST_CAPACITY;
      in_range = n > 0 && p >= 1 && p <= n;
      o = '0;
      o.status = ple_pkg::ST_OK;
      case (act)
         ple_pkg::ACT_CLEAR: list_q.delete();
         ple_pkg::ACT_INS_FRONT: begin
            if (full) o.status = ple_pkg::ST_FULL;
            else list_q.push_front(din);
         end
         ple_pkg::ACT_DEL_FRONT: begin
            if (n == 0) o.status = ple_pkg::ST_RANGE;
            else o.data_out = list_q.pop_front();
         end
         ple_pkg::ACT_APPEND: begin
            if (full) o.status = ple_pkg::ST_FULL;
            else list_q.push_back(din);
         end
         ple_pkg::ACT_REMOVE: begin
            if (!in_range) o.status = ple_pkg::ST_RANGE;
            else begin
               o.data_out = list_q[p-1];
               list_q.delete(p-1);
            end
         end
         ple_pkg::ACT_INS_BEFORE: begin
            // the full check wins over the position check
            if (full) o.status = ple_pkg::ST_FULL;
            else if (p > n) o.status = ple_pkg::ST_RANGE;
            else list_q.insert((p == 0) ? 0 : p - 1, din);
         end
         ple_pkg::ACT_INS_AFTER: begin
            if (full) o.status = ple_pkg::ST_FULL;
            else if (p > n) o.status = ple_pkg::ST_RANGE;
            else list_q.insert(p, din);
         end
         ple_pkg::ACT_SET: begin
            if (!in_range) o.status = ple_pkg::ST_RANGE;
            else list_q[p-1] = din;
         end
         ple_pkg::ACT_GET: begin
            if (!in_range) o.status = ple_pkg::ST_RANGE;
            else o.data_out = list_q[p-1];
         end
         default: o.status = ple_pkg::ST_RANGE;
      endcase
      o.count = 5'(list_q.size());
      o.is_empty = (list_q.size() == 0);
      return o;
   endfunction

   function automatic stim_row_type mk_row(input logic [3:0] act, input logic [4:0] pos,
                                           input logic [31:0] din, input logic [4:0] reps,
                                           input logic typed, input logic [1:0] st,
                                           input logic [31:0] dout, input logic [4:0] cnt,
                                           input logic emp);
      stim_row_type r;
      r.act = act;
      r.pos = pos;
      r.din = din;
      r.reps = reps;
      r.typed = typed;
      r.want.status = st;
      r.want.data_out = dout;
      r.want.count = cnt;
      r.want.is_empty = emp;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_PRINTED)
         $display("mismatch at %0t: %s got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // offers one word and waits for it to be taken; the predictor runs on acceptance
   task automatic send_word(input logic [3:0] act, input logic [4:0] pos,
                            input logic [31:0] din, input bit typed,
                            input outcome_type typed_want, input bit drain_first);
      int          gap;
      outcome_type predicted;
      if ($urandom_range(0, 49) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 8);
      if (drain_first && gap == 0) gap = 1;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         while (drain_first && outcome_q.size() != 0) @(posedge clock);
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= act;
      req_tdata  <= {3'b000, din, pos};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_action(act, pos, din);
      outcome_q.push_back(typed ? typed_want : predicted);
   endtask

   task automatic check_word();
      outcome_type got;
      outcome_type want;
      got.status   = rsp_tuser;
      got.data_out = rsp_tdata[31:0];
      got.count    = rsp_tdata[36:32];
      got.is_empty = rsp_tdata[37];
      if (outcome_q.size() == 0) begin
         report_mismatch("word with nothing outstanding", got.data_out, 32'd0);
         return;
      end
      want = outcome_q.pop_front();
      if (got.status != want.status) report_mismatch("status", got.status, want.status);
      if (got.data_out != want.data_out)
         report_mismatch("data_out", got.data_out, want.data_out);
      if (got.count != want.count) report_mismatch("count", got.count, want.count);
      if (got.is_empty != want.is_empty)
         report_mismatch("is_empty", got.is_empty, want.is_empty);
   endtask

   // result side: random stalls, plus one long hold-off when asked for
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) rsp_steady = !rsp_steady;
         stall = (rsp_steady ? 0 : $urandom_range(0, 8)) + rsp_hold_cycles;
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_word();
      end
   end

   initial begin
      logic [3:0]  act;
      logic [4:0]  pos;
      logic [31:0] din;
      int          r;
      int          n;
      bit          grow;
      stim_tbl[0]  = mk_row(ple_pkg::ACT_GET, 5'd1, 32'd0, 5'd1,
                            1, ple_pkg::ST_RANGE, 0, 0, 1);
      stim_tbl[1]  = mk_row(ple_pkg::ACT_DEL_FRONT, 5'd0, 32'd0, 5'd1,
                            1, ple_pkg::ST_RANGE, 0, 0, 1);
      stim_tbl[2]  = mk_row(ple_pkg::ACT_REMOVE, 5'd1, 32'd0, 5'd1,
                            1, ple_pkg::ST_RANGE, 0, 0, 1);
      stim_tbl[3]  = mk_row(ple_pkg::ACT_SET, 5'd1, 32'h0000_1234, 5'd1,
                            1, ple_pkg::ST_RANGE, 0, 0, 1);
      // on an empty list only position 0 inserts
      stim_tbl[4]  = mk_row(ple_pkg::ACT_INS_BEFORE, 5'd1, 32'd1, 5'd1,
                            1, ple_pkg::ST_RANGE, 0, 0, 1);
      stim_tbl[5]  = mk_row(ple_pkg::ACT_INS_AFTER, 5'd1, 32'd1, 5'd1,
                            1, ple_pkg::ST_RANGE, 0, 0, 1);
      stim_tbl[6]  = mk_row(ple_pkg::ACT_INS_BEFORE, 5'd0, 32'h8000_0000, 5'd1,
                            1, ple_pkg::ST_OK, 0, 1, 0);
      // position equal to the count appends
      stim_tbl[7]  = mk_row(ple_pkg::ACT_INS_AFTER, 5'd1, 32'h7fff_ffff, 5'd1,
                            1, ple_pkg::ST_OK, 0, 2, 0);
      stim_tbl[8]  = mk_row(ple_pkg::ACT_INS_FRONT, 5'd0, 32'hffff_ffff, 5'd1,
                            1, ple_pkg::ST_OK, 0, 3, 0);
      stim_tbl[9]  = mk_row(ple_pkg::ACT_APPEND, 5'd0, 32'd0, 5'd1,
                            1, ple_pkg::ST_OK, 0, 4, 0);
      stim_tbl[10] = mk_row(ple_pkg::ACT_GET, 5'd0, 32'd0, 5'd1,
                            1, ple_pkg::ST_RANGE, 0, 4, 0);
      stim_tbl[11] = mk_row(ple_pkg::ACT_GET, 5'd1, 32'd0, 5'd1,
                            1, ple_pkg::ST_OK, 32'hffff_ffff, 4, 0);
      stim_tbl[12] = mk_row(ple_pkg::ACT_SET, 5'd4, 32'h5555_5555, 5'd1,
                            0, ple_pkg::ST_OK, 0, 0, 0);
      stim_tbl[13] = mk_row(ple_pkg::ACT_INS_AFTER, 5'd0, 32'haaaa_aaaa, 5'd1,
                            0, ple_pkg::ST_OK, 0, 0, 0);
      stim_tbl[14] = mk_row(ple_pkg::ACT_INS_BEFORE, 5'd6, 32'd7, 5'd1,
                            1, ple_pkg::ST_RANGE, 0, 5, 0);
      stim_tbl[15] = mk_row(ple_pkg::ACT_INS_BEFORE, 5'd1, 32'h0000_0001, 5'd1,
                            0, ple_pkg::ST_OK, 0, 0, 0);
      stim_tbl[16] = mk_row(ple_pkg::ACT_REMOVE, 5'd3, 32'd0, 5'd1,
                            0, ple_pkg::ST_OK, 0, 0, 0);
      stim_tbl[17] = mk_row(ple_pkg::ACT_DEL_FRONT, 5'd0, 32'd0, 5'd1,
                            0, ple_pkg::ST_OK, 0, 0, 0);
      stim_tbl[18] = mk_row(ACT_UNUSED_LAST, 5'd2, 32'd9, 5'd1,
                            1, ple_pkg::ST_RANGE, 0, 4, 0);
      stim_tbl[19] = mk_row(ple_pkg::ACT_APPEND, 5'd0, 32'h1357_9bdf, 5'd12,
                            0, ple_pkg::ST_OK, 0, 0, 0);
      stim_tbl[20] = mk_row(ple_pkg::ACT_INS_FRONT, 5'd0, 32'd3, 5'd1,
                            1, ple_pkg::ST_FULL, 0, 16, 0);
      stim_tbl[21] = mk_row(ple_pkg::ACT_INS_BEFORE, 5'd31, 32'd3, 5'd1,
                            1, ple_pkg::ST_FULL, 0, 16, 0);
      stim_tbl[22] = mk_row(ple_pkg::ACT_INS_AFTER, 5'd0, 32'd3, 5'd1,
                            1, ple_pkg::ST_FULL, 0, 16, 0);
      stim_tbl[23] = mk_row(ple_pkg::ACT_GET, 5'd16, 32'd0, 5'd1,
                            0, ple_pkg::ST_OK, 0, 0, 0);
      stim_tbl[24] = mk_row(ple_pkg::ACT_REMOVE, 5'd16, 32'd0, 5'd1,
                            0, ple_pkg::ST_OK, 0, 0, 0);
      stim_tbl[25] = mk_row(ple_pkg::ACT_CLEAR, 5'd0, 32'd0, 5'd1,
                            1, ple_pkg::ST_OK, 0, 0, 1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_tbl[i]) begin
         for (int k = 0; k < stim_tbl[i].reps; k++)
            send_word(stim_tbl[i].act, stim_tbl[i].pos, stim_tbl[i].din + k,
                      stim_tbl[i].typed, stim_tbl[i].want, 1'b0);
      end

      // random part: long growing and shrinking phases so the list hits full and empty
      grow = 1'b1;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         n = list_q.size();
         if (n >= LIST_CAPACITY) grow = 1'b0;
         else if (n == 0) grow = 1'b1;
         else if ($urandom_range(0, 49) == 0) grow = !grow;
         r = $urandom_range(0, 99);
         if (r < 1) act = ple_pkg::ACT_CLEAR;
         else if (r < 4) act = 4'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
         else if (r < 16) act = ple_pkg::ACT_GET;
         else if (r < 26) act = ple_pkg::ACT_SET;
         else if (($urandom_range(0, 99) < 70) == grow) begin
            case ($urandom_range(0, 3))
               0: act = ple_pkg::ACT_INS_FRONT;
               1: act = ple_pkg::ACT_APPEND;
               2: act = ple_pkg::ACT_INS_BEFORE;
               default: act = ple_pkg::ACT_INS_AFTER;
            endcase
         end else
            act = ($urandom_range(0, 2) == 0) ? ple_pkg::ACT_DEL_FRONT : ple_pkg::ACT_REMOVE;
         if ($urandom_range(0, 9) < 8) pos = 5'($urandom_range(0, n + 1));
         else pos = 5'($urandom_range(0, 31));
         case ($urandom_range(0, 19))
            0: din = 32'h8000_0000;
            1: din = 32'h7fff_ffff;
            2: din = 32'hffff_ffff;
            3: din = 32'd0;
            default: din = $urandom;
         endcase
         if (i == 300) rsp_hold_cycles = HOLD_CYCLES;
         send_word(act, pos, din, 1'b0, '0, i == 700);
      end

      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
